// File: rtl/srs_pkg.sv
// Shared types and constants of the sorted range search unit.
`timescale 1ns / 1ps

package srs_pkg;

  // Store geometry
  localparam int unsigned StoreDepth = 1024;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned CntW       = $clog2(StoreDepth + 1);
  localparam int unsigned PosW       = CntW + 1;   // signed search bound
  localparam int unsigned DataW      = 32;
  localparam int unsigned IdxW       = 11;         // result index width

  // Result index for a key that is not present
  localparam logic [IdxW-1:0] IdxNone = '1;

  // Item kinds carried on the input tuser
  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_QUERY  = 2'd2
  } srs_action_e;

  // Search engine sequencer
  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_PROBE,
    S_FIN
  } srs_state_e;

  // Query request into the search engine
  typedef struct packed {
    logic                    start;
    logic signed [DataW-1:0] key;
    logic [CntW-1:0]         count;
  } srs_req_t;

  // Search engine status and result
  typedef struct packed {
    logic            busy;
    logic            done;
    logic [IdxW-1:0] first;
    logic [IdxW-1:0] last;
  } srs_rsp_t;

endpackage

// File: rtl/srs_store.sv
// Value store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module srs_store
  import srs_pkg::*;
(
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [DataW-1:0] rd_data_o
);

  logic [DataW-1:0] mem [StoreDepth];
  logic [DataW-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/srs_search.sv
// Binary search engine: first pass for the lowest match, second (after a hit only) for the highest.
`timescale 1ns / 1ps

module srs_search
  import srs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  srs_req_t         req_i,
  input  logic             res_ready_i,
  output logic             rd_en_o,
  output logic [AddrW-1:0] rd_addr_o,
  input  logic [DataW-1:0] rd_data_i,
  output srs_rsp_t         rsp_o
);

  srs_state_e state_q, state_d;

  logic signed [PosW-1:0]  lo_q, lo_d, hi_q, hi_d, hi_init_q, hi_init_d;
  logic signed [PosW-1:0]  mid_q, mid_d;
  logic signed [DataW-1:0] key_q, key_d;
  logic [IdxW-1:0]         hit_q, hit_d, first_q, first_d, last_q, last_d;
  logic                    pass_q, pass_d;

  // Probe evaluation
  logic signed [PosW-1:0]  lo_x, hi_x, sum_x;
  logic [IdxW-1:0]         hit_x;
  logic                    cont;
  logic                    v_eq, v_lt;

  assign v_eq = (rd_data_i == key_q);
  assign v_lt = ($signed(rd_data_i) < key_q);

  // Bounds after this cycle's probe (or the current bounds when starting)
  always_comb begin
    lo_x  = lo_q;
    hi_x  = hi_q;
    hit_x = hit_q;
    if (state_q == S_PROBE) begin
      if (v_eq) begin
        hit_x = IdxW'(mid_q);
        if (pass_q) begin
          lo_x = mid_q + PosW'(1);
        end else begin
          hi_x = mid_q - PosW'(1);
        end
      end else if (v_lt) begin
        lo_x = mid_q + PosW'(1);
      end else begin
        hi_x = mid_q - PosW'(1);
      end
    end
  end

  assign cont      = (lo_x <= hi_x);
  assign sum_x     = lo_x + hi_x;
  assign mid_d     = $signed({1'b0, sum_x[PosW-1:1]});
  assign rd_addr_o = mid_d[AddrW-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.start) state_d = S_START;
      end
      S_START, S_PROBE: begin
        if (cont) begin
          state_d = S_PROBE;
        end else if (!pass_q && (hit_x != IdxNone)) begin
          state_d = S_START;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    lo_d      = lo_q;
    hi_d      = hi_q;
    hi_init_d = hi_init_q;
    key_d     = key_q;
    hit_d     = hit_q;
    first_d   = first_q;
    last_d    = last_q;
    pass_d    = pass_q;
    rd_en_o   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          key_d     = req_i.key;
          lo_d      = '0;
          hi_init_d = $signed(PosW'(req_i.count)) - PosW'(1);
          hi_d      = $signed(PosW'(req_i.count)) - PosW'(1);
          hit_d     = IdxNone;
          pass_d    = 1'b0;
        end
      end
      S_START, S_PROBE: begin
        lo_d  = lo_x;
        hi_d  = hi_x;
        hit_d = hit_x;
        if (cont) begin
          rd_en_o = 1'b1;
        end else if (!pass_q) begin
          // first pass over: stop on a miss, else search for the highest match
          first_d = hit_x;
          last_d  = IdxNone;
          pass_d  = 1'b1;
          lo_d    = '0;
          hi_d    = hi_init_q;
          hit_d   = IdxNone;
        end else begin
          last_d = hit_x;
        end
      end
      S_FIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    hi_init_q <= hi_init_d;
    key_q     <= key_d;
    hit_q     <= hit_d;
    first_q   <= first_d;
    last_q    <= last_d;
    if (rd_en_o) mid_q <= mid_d;
  end

  assign rsp_o.busy  = (state_q != S_IDLE);
  assign rsp_o.done  = (state_q == S_FIN);
  assign rsp_o.first = first_q;
  assign rsp_o.last  = last_q;

endmodule

// File: rtl/sorted_range_search_unit.sv
// Top level of the sorted range search unit: stream ports, count and result register.
`timescale 1ns / 1ps

// Keeps up to 1024 signed 32-bit values; the user must append them in nondecreasing
// order, which the block does not enforce. The input tuser says what an item is:
// append (tdata[31:0] is the value), clear, or query (tdata[63:32] is the key);
// code 3 is ignored. Append and clear give no result; an append to a full store
// is dropped. A query runs two binary searches over the store memory, one probe
// per cycle, and returns the first and last index of the key (all ones, i.e. -1,
// if absent); the second search is skipped on a miss. Appends and clears are
// taken while a result waits on the output register.
module sorted_range_search_unit
  import srs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [31:0] element_value, [63:32] search_key
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] action
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // [10:0] first_index, [21:11] last_index, pad
);

  logic [CntW-1:0]  count_q, count_d;
  logic             in_xfer;
  srs_action_e      action;
  logic             wr_en;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [DataW-1:0] rd_data;
  srs_req_t         req;
  srs_rsp_t         rsp;
  logic             res_ready;
  logic             out_valid_q;
  logic [IdxW-1:0]  out_first_q, out_last_q;

  assign s_axis_tready_o = !rsp.busy;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign action          = srs_action_e'(s_axis_tuser_i);

  // Stored count update
  always_comb begin
    count_d = count_q;
    wr_en   = 1'b0;
    if (in_xfer) begin
      unique case (action)
        ACT_APPEND: begin
          if (count_q < CntW'(StoreDepth)) begin
            wr_en   = 1'b1;
            count_d = count_q + CntW'(1);
          end
        end
        ACT_CLEAR: count_d = '0;
        ACT_QUERY: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  srs_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[AddrW-1:0]),
    .wr_data_i (s_axis_tdata_i[DataW-1:0]),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Query request
  assign req.start = in_xfer && (action == ACT_QUERY);
  assign req.key   = $signed(s_axis_tdata_i[2*DataW-1:DataW]);
  assign req.count = count_q;

  srs_search u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .res_ready_i (res_ready),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .rsp_o       (rsp)
  );

  // Output register
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp.done && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp.done && res_ready) begin
      out_first_q <= rsp.first;
      out_last_q  <= rsp.last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_last_q, out_first_q};

`ifndef NO_ASSERTIONS
  // Count never passes the store depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(StoreDepth))
    else $error("stored count exceeds store depth");

  // A query transfer starts the search engine
  a_query_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.start |=> rsp.busy)
    else $error("query did not start the search");

  // A finished search waits while the output register is full
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.done && !res_ready) |=> (rsp.done && $stable(rsp.first) && $stable(rsp.last)))
    else $error("search result lost while output stalled");

  // A miss on the first index is a miss on the last as well
  a_miss_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_first_q == IdxNone)) |-> (out_last_q == IdxNone))
    else $error("inconsistent miss result");

  // No store write while a search is running
  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.busy |-> !wr_en)
    else $error("store written during search");
`endif

endmodule

// File: tb/tb_sorted_range_search_unit.sv
// Self-checking testbench for the sorted range search unit: stream driver, predictor, monitor.
`timescale 1ns / 1ps

module tb_sorted_range_search_unit
  import srs_pkg::*;
();

  // Action code that the block ignores
  localparam logic [1:0] ActUnused = 2'd3;

  localparam logic signed [DataW-1:0] MinVal = 32'sh8000_0000;
  localparam logic signed [DataW-1:0] MaxVal = 32'sh7FFF_FFFF;

  localparam int IdleLimit   = 2000;  // cycles without any transfer
  localparam int DrainCycles = 40;    // cycles run after the last expected result
  localparam int ItemTarget  = 950;   // includes one long sorted run
  localparam int LargeFill   = 300;   // length of the long run

  typedef struct packed {
    logic [1:0]              act;
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] key;
  } item_t;

  typedef struct packed {
    logic [IdxW-1:0] first;
    logic [IdxW-1:0] last;
  } range_t;

  logic        clk_i;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [63:0] s_data  = '0;
  logic [1:0]  s_user  = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [23:0] m_data;

  sorted_range_search_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  // Stimulus queue and the stimulus side's own view of the store
  item_t                   pending_items[$];
  logic signed [DataW-1:0] gen_vals[$];

  // Predictor state
  logic signed [DataW-1:0] sorted_mirror [StoreDepth];
  int unsigned             mirror_count = 0;
  range_t                  expected_ranges[$];

  int    error_count = 0;
  int    idle_cycles = 0;
  bit    in_taken    = 1'b0;
  bit    out_taken   = 1'b0;
  int    in_gap      = 0;
  int    out_stall   = 0;
  int    in_calm     = 0;
  int    out_calm    = 0;
  item_t next_item;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Wait length per transfer, with occasional runs of back-to-back transfers
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Binary search over the mirror; lowest or highest index holding the key
  function automatic int edge_index(input logic signed [DataW-1:0] key, input bit want_last);
    int lo, hi, mid, hit;
    lo  = 0;
    hi  = int'(mirror_count) - 1;
    hit = -1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (sorted_mirror[mid] == key) begin
        hit = mid;
        if (want_last) lo = mid + 1;
        else hi = mid - 1;
      end else if (sorted_mirror[mid] < key) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return hit;
  endfunction

  // Update the mirror for one accepted transfer; queries queue an expected range
  task automatic apply_transfer(input logic [1:0] act, input logic signed [DataW-1:0] value,
                                input logic signed [DataW-1:0] key);
    int     first, last;
    range_t r;
    case (act)
      ACT_APPEND: begin
        if (mirror_count < StoreDepth) begin
          sorted_mirror[mirror_count] = value;
          mirror_count++;
        end
      end
      ACT_CLEAR: mirror_count = 0;
      ACT_QUERY: begin
        first = edge_index(key, 1'b0);
        last  = (first == -1) ? -1 : edge_index(key, 1'b1);
        r.first = IdxW'(first);
        r.last  = IdxW'(last);
        expected_ranges.push_back(r);
      end
      default: ;
    endcase
  endtask

  // Stimulus builders
  task automatic push_item(input logic [1:0] act, input logic signed [DataW-1:0] value,
                           input logic signed [DataW-1:0] key);
    item_t it;
    it.act   = act;
    it.value = value;
    it.key   = key;
    pending_items.push_back(it);
  endtask

  task automatic add_append(input logic signed [DataW-1:0] v);
    push_item(ACT_APPEND, v, $urandom());
    if (gen_vals.size() < StoreDepth) gen_vals.push_back(v);
  endtask

  task automatic add_clear();
    push_item(ACT_CLEAR, $urandom(), $urandom());
    gen_vals.delete();
  endtask

  task automatic add_query(input logic signed [DataW-1:0] k);
    push_item(ACT_QUERY, $urandom(), k);
  endtask

  // Mostly stored values, some near misses and keys outside the stored span
  function automatic logic signed [DataW-1:0] pick_key();
    int n, roll, i;
    n    = gen_vals.size();
    roll = $urandom_range(0, 9);
    if (n == 0 || roll == 9) return $urandom();
    i = $urandom_range(0, n - 1);
    if (roll < 6) return gen_vals[i];
    if (roll == 6) return ($urandom_range(0, 1) != 0) ? gen_vals[i] + 1 : gen_vals[i] - 1;
    if (roll == 7) return gen_vals[0] - 1;
    return gen_vals[n - 1] + 1;
  endfunction

  // Nondecreasing run; mode 0 dense with duplicates, 1 medium steps, 2 spans the full range
  task automatic fill_sorted(input int n, input int mode);
    longint v, d;
    case (mode)
      0:       v = longint'(int'($urandom_range(0, 64)) - 32);
      1:       v = longint'($signed($urandom()));
      default: v = longint'(MinVal) + $urandom_range(0, 3);
    endcase
    for (int i = 0; i < n; i++) begin
      add_append(v[DataW-1:0]);
      if ($urandom_range(0, 3) == 0) d = 0;
      else if (mode == 0) d = $urandom_range(1, 2);
      else if (mode == 1) d = $urandom_range(1, 1000);
      else d = longint'($urandom_range(1, 32'h1000_0000));
      v = v + d;
      if (v > longint'(MaxVal)) v = longint'(MaxVal);
    end
  endtask

  // Input side: present items at the falling edge, idling a random gap (possibly none) between them
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_valid || in_taken) begin
        in_taken = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
          s_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          next_item = pending_items.pop_front();
          s_valid <= 1'b1;
          s_data  <= {next_item.key, next_item.value};
          s_user  <= next_item.act;
          in_gap  = draw_wait(in_calm);
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Input transfers feed the predictor
  always @(posedge clk_i) begin
    if (s_valid && s_ready) begin
      in_taken = 1'b1;
      apply_transfer(s_user, s_data[31:0], s_data[63:32]);
    end
  end

  // Result side: after each transfer, hold tready low for a randomly drawn stall (possibly none)
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        out_taken = 1'b0;
        out_stall = draw_wait(out_calm);
      end
      if (out_stall > 0) begin
        out_stall--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // Compare each result transfer with the oldest expected range
  always @(posedge clk_i) begin
    range_t want;
    if (m_valid && m_ready) begin
      out_taken = 1'b1;
      if (expected_ranges.size() == 0) begin
        report_mismatch($sformatf("result with none expected: first %0d last %0d",
                                  $signed(m_data[10:0]), $signed(m_data[21:11])));
      end else begin
        want = expected_ranges.pop_front();
        if (m_data[10:0] !== want.first)
          report_mismatch($sformatf("first_index: got %0d want %0d",
                                    $signed(m_data[10:0]), $signed(want.first)));
        if (m_data[21:11] !== want.last)
          report_mismatch($sformatf("last_index: got %0d want %0d",
                                    $signed(m_data[21:11]), $signed(want.last)));
      end
    end
  end

  // Watchdog on cycles with no transfer on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_valid && s_ready) || (m_valid && m_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("sorted_range_search_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int  n, roll, kind;
    bit  long_done;
    long_done = 1'b0;

    // Directed: empty store, ignored code, range extremes, duplicates, clear
    add_query(32'sd0);
    push_item(ActUnused, MaxVal, MinVal);
    add_append(MinVal);
    add_append(MinVal);
    add_append(-32'sd1);
    add_append(32'sd0);
    add_append(32'sd0);
    add_append(32'sd0);
    add_append(MaxVal);
    add_append(MaxVal);
    add_query(MinVal);
    add_query(32'sd0);
    add_query(MaxVal);
    add_query(-32'sd1);
    add_query(32'sd5);
    add_query(-32'sd2);
    push_item(ActUnused, '1, '1);
    add_query(32'sd0);
    add_clear();
    add_query(32'sd0);
    add_append(32'sd42);
    add_query(32'sd42);
    add_query(32'sd41);
    add_clear();

    // Random sequences: mostly clear, sorted fill, queries; some noise
    while (pending_items.size() < ItemTarget) begin
      roll = $urandom_range(0, 99);
      if (!long_done && pending_items.size() > 400) begin
        // One long run with many duplicates for deeper searches
        long_done = 1'b1;
        add_clear();
        n = -600;
        for (int i = 0; i < LargeFill; i++) begin
          add_append(n);
          n += $urandom_range(0, 1);
        end
        repeat (6) add_append(MaxVal);
        add_query(gen_vals[0]);
        add_query(gen_vals[LargeFill-1]);
        add_query(MaxVal);
        repeat (6) add_query(pick_key());
      end else if (roll < 85) begin
        add_clear();
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 24);
        fill_sorted(n, $urandom_range(0, 2));
        repeat ($urandom_range(2, 8)) add_query(pick_key());
      end else begin
        kind = $urandom_range(0, 3);
        case (kind)
          0: begin
            push_item(ActUnused, $urandom(), $urandom());
            add_query(pick_key());
          end
          1: begin
            // unsorted contents
            add_clear();
            repeat ($urandom_range(1, 12)) add_append($urandom());
            repeat (3) add_query(pick_key());
          end
          2: begin
            add_clear();
            add_query($urandom());
          end
          default: begin
            // appends mixed in among queries
            repeat ($urandom_range(1, 4)) begin
              add_append((gen_vals.size() > 0) ? gen_vals[$] + $urandom_range(0, 3)
                                               : $urandom());
              add_query(pick_key());
            end
          end
        endcase
      end
    end

    // Reset, then let the stream run
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_items.size() > 0 || s_valid) @(posedge clk_i);
    while (expected_ranges.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("sorted_range_search_unit regression: pass");
    end else begin
      $display("sorted_range_search_unit regression: fail");
    end
    $finish;
  end

endmodule
